// ----- rtl/crtc_pkg.sv -----
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types and codes of the congruence combiner: status codes, datapath
// operations, controller states and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package crtc_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INCOMPAT = 2'd1;
  localparam logic [1:0] ST_OVFL     = 2'd2;

  typedef enum logic [3:0] {
    OP_LOAD,  // latch the congruence, apply start
    OP_RED,   // r = residue mod m
    OP_RQ,    // diff = p - (r mod q) mod q, gcd init
    OP_GCD,   // one Euclid step on (ga, gb)
    OP_CHK,   // diff mod g, keep diff / g
    OP_NQ,    // n = q / g
    OP_LIM,   // limit / m, overflow test
    OP_QN,    // qn = n * m
    OP_MG,    // m / g
    OP_A0,    // (m / g) mod n, inverse init
    OP_DG,    // (diff / g) mod n
    OP_INVD,  // extended Euclid quotient step
    OP_INVM,  // extended Euclid coefficient update
    OP_K,     // k = dg * inv mod n
    OP_FIN    // p = r + m * k, q = qn
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_GO   = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic cap;
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic st_nz;
    logic gb_zero;
    logic n_le1;
    logic r1_zero;
  } dp_stat_t;

  function automatic logic is_mm(op_t op);
    logic r;
    r = (op == OP_QN) || (op == OP_INVM) || (op == OP_K) || (op == OP_FIN);
    return r;
  endfunction

endpackage

// ----- rtl/crtc_if.sv -----
// ----------------------------------------------------------------------------
// crtc_in_if / crtc_out_if
// Valid/ready channels for congruences in and combined systems out.
// ----------------------------------------------------------------------------
interface crtc_in_if #(parameter int MODULUS_BITS = 32);
  logic                    valid;
  logic                    ready;
  logic [MODULUS_BITS-1:0] residue;
  logic [MODULUS_BITS-1:0] modulus;
  logic                    start_req;
  modport source (output valid, output residue, output modulus, output start_req,
                  input ready);
  modport sink   (input valid, input residue, input modulus, input start_req,
                  output ready);
endinterface

interface crtc_out_if #(parameter int RESULT_BITS = 62);
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] combined_residue;
  logic [RESULT_BITS-1:0] combined_modulus;
  logic [1:0]             status;
  modport source (output valid, output combined_residue, output combined_modulus,
                  output status, input ready);
  modport sink   (input valid, input combined_residue, input combined_modulus,
                  input status, output ready);
endinterface

// ----- rtl/crt_congruence_combiner_core.sv -----
// ----------------------------------------------------------------------------
// crt_congruence_combiner_core
// Generalized CRT combiner: folds x = residue mod modulus into x = p mod q.
// Datapath width DW = max(MODULUS_BITS, RESULT_BITS); every divide and modular
// multiply runs on the shared units, the Euclid loops repeating per gcd and
// inverse step; an item under a sticky error stops after its reduction.
// One item at a time; the shared divider and the Euclid loops set the rate.
// Reset: system x = 0 mod 1, status ok, input ready for a transfer.
// ----------------------------------------------------------------------------
module crt_congruence_combiner_core
  import crtc_pkg::*;
#(
  parameter int MODULUS_BITS = 32,
  parameter int RESULT_BITS  = 62
) (
  input logic clk,
  input logic rst_n,
  crtc_in_if.sink    in_if,
  crtc_out_if.source out_if
);
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // controller: one operation of the datapath at a time
  crtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: system state drives the result fields directly; it holds
  // steady from the end of the item until the result transfer
  crtc_datapath #(
    .MODULUS_BITS(MODULUS_BITS),
    .RESULT_BITS (RESULT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_residue  (in_if.residue),
    .in_modulus  (in_if.modulus),
    .in_start_req(in_if.start_req),
    .sys_residue (out_if.combined_residue),
    .sys_modulus (out_if.combined_modulus),
    .sys_status  (out_if.status)
  );

  // a valid ok result is a reduced residue
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status == ST_OK) |->
      out_if.combined_residue < out_if.combined_modulus)
    else $error("residue not reduced");
  assert property (@(posedge clk) disable iff (!rst_n) !(in_if.ready && out_if.valid))
    else $error("input open while result pending");
endmodule

// ----- rtl/crtc_div.sv -----
// ----------------------------------------------------------------------------
// crtc_div
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module crtc_div #(
  parameter int DW = 62
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(DW);

  logic [DW-1:0] quo_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[DW-2:0], ge};
        rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// ----- rtl/crtc_mulmod.sv -----
// ----------------------------------------------------------------------------
// crtc_mulmod
// Shift-add modular multiplier a*b mod n, one multiplier bit per cycle.
// Expects a <= n and b < n.
// ----------------------------------------------------------------------------
module crtc_mulmod #(
  parameter int DW = 62
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  input  logic [DW:0]   n,
  output logic          done,
  output logic [DW-1:0] prod
);
  logic [DW:0]   a_r, acc_r, n_r;
  logic [DW-1:0] b_r;
  logic          busy_r, done_r;
  logic [DW+1:0] acc_sum, a_dbl;
  logic [DW:0]   a_in;

  always_comb begin
    a_in    = ({1'b0, a} >= n) ? ({1'b0, a} - n) : {1'b0, a};
    acc_sum = {1'b0, acc_r} + {1'b0, a_r};
    a_dbl   = {a_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a_in;
        b_r    <= b;
        n_r    <= n;
        acc_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) begin
            acc_r <= (acc_sum >= {1'b0, n_r}) ? (DW+1)'(acc_sum - {1'b0, n_r})
                                              : acc_sum[DW:0];
          end
          a_r <= (a_dbl >= {1'b0, n_r}) ? (DW+1)'(a_dbl - {1'b0, n_r}) : a_dbl[DW:0];
          b_r <= b_r >> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r[DW-1:0];
endmodule

// ----- rtl/crtc_datapath.sv -----
// ----------------------------------------------------------------------------
// crtc_datapath
// System registers, working registers, shared divider and modular multiplier.
// ----------------------------------------------------------------------------
module crtc_datapath
  import crtc_pkg::*;
#(
  parameter int MODULUS_BITS = 32,
  parameter int RESULT_BITS  = 62
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_stat_t                stat,
  input  logic [MODULUS_BITS-1:0] in_residue,
  input  logic [MODULUS_BITS-1:0] in_modulus,
  input  logic                    in_start_req,
  output logic [RESULT_BITS-1:0]  sys_residue,
  output logic [RESULT_BITS-1:0]  sys_modulus,
  output logic [1:0]              sys_status
);
  localparam int DW = (MODULUS_BITS > RESULT_BITS) ? MODULUS_BITS : RESULT_BITS;
  localparam logic [DW:0]   ONE_W   = 1;
  localparam logic [DW:0]   MOD_TOP = ONE_W << RESULT_BITS;
  localparam logic [DW:0]   LIM_W   = MOD_TOP - ONE_W;
  localparam logic [DW-1:0] LIMIT   = LIM_W[DW-1:0];

  logic [DW-1:0] p_r, q_r, m_r, r_r, diff_r, ga_r, gb_r, n_r, qn_r;
  logic [DW-1:0] mg_r, dg_r, r0_r, r1_r, t0_r, t1_r, qt_r, k_r;
  logic [1:0]    st_r;

  logic          div_start, mm_start, div_done, mm_done;
  logic [DW-1:0] div_a, div_b, div_quo, div_rem;
  logic [DW-1:0] mm_a, mm_b, mm_prod;
  logic [DW:0]   mm_n;

  assign div_start = cmd.start && !is_mm(cmd.op);
  assign mm_start  = cmd.start && is_mm(cmd.op);

  always_comb begin
    div_a = r_r;
    div_b = m_r;
    mm_a  = n_r;
    mm_b  = m_r;
    mm_n  = MOD_TOP;
    unique case (cmd.op)
      OP_RQ:   begin div_a = r_r;    div_b = q_r;  end
      OP_GCD:  begin div_a = ga_r;   div_b = gb_r; end
      OP_CHK:  begin div_a = diff_r; div_b = ga_r; end
      OP_NQ:   begin div_a = q_r;    div_b = ga_r; end
      OP_LIM:  begin div_a = LIMIT;  div_b = m_r;  end
      OP_MG:   begin div_a = m_r;    div_b = ga_r; end
      OP_A0:   begin div_a = mg_r;   div_b = n_r;  end
      OP_DG:   begin div_a = dg_r;   div_b = n_r;  end
      OP_INVD: begin div_a = r0_r;   div_b = r1_r; end
      OP_INVM: begin mm_a = qt_r; mm_b = t1_r; mm_n = {1'b0, n_r};  end
      OP_K:    begin mm_a = dg_r; mm_b = t0_r; mm_n = {1'b0, n_r};  end
      OP_FIN:  begin mm_a = m_r;  mm_b = k_r;  mm_n = {1'b0, qn_r}; end
      default: ;
    endcase
  end

  crtc_div #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  crtc_mulmod #(.DW(DW)) u_mm (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .a(mm_a), .b(mm_b), .n(mm_n),
    .done(mm_done), .prod(mm_prod)
  );

  // system state: reset to x = 0 mod 1, ok
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r  <= '0;
      q_r  <= DW'(1);
      st_r <= ST_OK;
    end else if (cmd.load) begin
      if (in_start_req) begin
        p_r  <= '0;
        q_r  <= DW'(1);
        st_r <= ST_OK;
      end
    end else if (cmd.cap) begin
      case (cmd.op)
        OP_CHK: if (div_rem != '0) st_r <= ST_INCOMPAT;
        OP_LIM: if (n_r > div_quo) st_r <= ST_OVFL;
        OP_FIN: begin
          p_r <= mm_prod + r_r;
          q_r <= qn_r;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r <= (in_modulus == '0) ? DW'(1) : DW'(in_modulus);
      r_r <= DW'(in_residue);
    end else if (cmd.cap) begin
      case (cmd.op)
        OP_RED: r_r <= div_rem;
        OP_RQ: begin
          diff_r <= (p_r >= div_rem) ? (p_r - div_rem) : (p_r + (q_r - div_rem));
          ga_r   <= m_r;
          gb_r   <= q_r;
        end
        OP_GCD: begin
          ga_r <= gb_r;
          gb_r <= div_rem;
        end
        OP_CHK: dg_r <= div_quo;
        OP_NQ:  n_r  <= div_quo;
        OP_QN: begin
          qn_r <= mm_prod;
          k_r  <= '0;
        end
        OP_MG: mg_r <= div_quo;
        OP_A0: begin
          r0_r <= n_r;
          r1_r <= div_rem;
          t0_r <= '0;
          t1_r <= DW'(1);
        end
        OP_DG: dg_r <= div_rem;
        OP_INVD: begin
          qt_r <= div_quo;
          r0_r <= r1_r;
          r1_r <= div_rem;
        end
        OP_INVM: begin
          t0_r <= t1_r;
          t1_r <= (t0_r >= mm_prod) ? (t0_r - mm_prod) : (t0_r + (n_r - mm_prod));
        end
        OP_K: k_r <= mm_prod;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.done    = div_done || mm_done;
    stat.st_nz   = st_r != ST_OK;
    stat.gb_zero = gb_r == '0;
    stat.n_le1   = n_r <= DW'(1);
    stat.r1_zero = r1_r == '0;
  end

  assign sys_residue = p_r[RESULT_BITS-1:0];
  assign sys_modulus = q_r[RESULT_BITS-1:0];
  assign sys_status  = st_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OK) || (st_r == ST_INCOMPAT) || (st_r == ST_OVFL))
    else $error("status code out of range");
endmodule

// ----- rtl/crtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// crtc_ctrl
// Sequencer: picks the next datapath operation, launches it, waits for it.
// ----------------------------------------------------------------------------
module crtc_ctrl
  import crtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd,
  input  dp_stat_t  stat
);
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt, dec_op;
  logic   dec_out;

  always_comb begin
    dec_out = 1'b0;
    dec_op  = OP_RED;
    unique case (op_r) inside
      OP_LOAD: dec_op = OP_RED;
      OP_RED:  begin dec_out = stat.st_nz; dec_op = OP_RQ; end
      OP_RQ, OP_GCD: dec_op = stat.gb_zero ? OP_CHK : OP_GCD;
      OP_CHK:  begin dec_out = stat.st_nz; dec_op = OP_NQ; end
      OP_NQ:   dec_op = OP_LIM;
      OP_LIM:  begin dec_out = stat.st_nz; dec_op = OP_QN; end
      OP_QN:   dec_op = stat.n_le1 ? OP_FIN : OP_MG;
      OP_MG:   dec_op = OP_A0;
      OP_A0:   dec_op = OP_DG;
      OP_DG, OP_INVM: dec_op = stat.r1_zero ? OP_K : OP_INVD;
      OP_INVD: dec_op = OP_INVM;
      OP_K:    dec_op = OP_FIN;
      OP_FIN:  dec_out = 1'b1;
      default: dec_out = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = S_DEC;
        op_nxt    = OP_LOAD;
      end
      S_DEC: begin
        if (dec_out) state_nxt = S_OUT;
        else begin
          state_nxt = S_GO;
          op_nxt    = dec_op;
        end
      end
      S_GO:   state_nxt = S_WAIT;
      S_WAIT: if (stat.done) state_nxt = S_DEC;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_LOAD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    cmd.load  = (state_r == S_IDLE) && in_valid;
    cmd.start = state_r == S_GO;
    cmd.cap   = (state_r == S_WAIT) && stat.done;
    cmd.op    = op_r;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

  assert property (@(posedge clk) disable iff (!rst_n) cmd.start |=> state_r == S_WAIT)
    else $error("launch not followed by wait");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("result transfer did not return to idle");
endmodule
